/* rtl/srb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types, constants and key helpers for the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned CntW       = $clog2(StoreDepth + 1);

  localparam logic [2:0] AddrTwoLevel  = 3'd0;
  localparam logic [2:0] AddrUnordered = 3'd4;

  typedef struct packed {
    logic [31:0] chunk_id;
    logic [30:0] batch_id;
    logic        end_of_chunk;
    logic [6:0]  slot_count;
    logic [47:0] data_offset;
    logic [47:0] data_length;
  } srb_in_t;

  typedef struct packed {
    logic [31:0] out_chunk_id;
    logic [30:0] out_batch_id;
    logic        out_end_of_chunk;
    logic [47:0] out_offset;
    logic [47:0] out_length;
    logic        overflow;
    logic        run_last;
  } srb_out_t;

  typedef enum logic {
    SrcInput   = 1'b0,
    SrcPending = 1'b1
  } srb_src_e;

  typedef struct packed {
    logic     load_in;
    logic     adv_in;
    logic     adv_head;
    logic     pop;
    logic     calc_lt;
    logic     insert;
    logic     emit;
    srb_src_e emit_src;
    logic     emit_ovf;
    logic     emit_last;
  } srb_cmd_t;

  typedef struct packed {
    logic unordered;
    logic in_match;
    logic full;
    logic head_match;
  } srb_sts_t;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StDecide = 4'b0010,
    StInsert = 4'b0100,
    StCheck  = 4'b1000
  } srb_state_e;

  function automatic logic key_match(srb_in_t e, logic [31:0] exp_major,
                                     logic [30:0] exp_minor, logic two_level);
    if (two_level) begin
      return (e.chunk_id == exp_major) && (e.batch_id == exp_minor);
    end
    return e.chunk_id == exp_major;
  endfunction

  // strict less-than, so a new packet lands ahead of equal keys
  function automatic logic key_lt(srb_in_t a, srb_in_t b, logic two_level);
    if (two_level) begin
      return {a.chunk_id, a.batch_id} < {b.chunk_id, b.batch_id};
    end
    return a.chunk_id < b.chunk_id;
  endfunction

endpackage

/* rtl/srb_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_ctrl
// Sequencer: classifies each packet, then stores, releases or drains.
// ----------------------------------------------------------------------------
module srb_ctrl import srb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  srb_sts_t sts_i,
  output srb_cmd_t cmd_o
);

  srb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load_in = 1'b1;
          state_d       = StDecide;
        end
      end
      StDecide: begin
        if (sts_i.unordered) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_src  = SrcInput;
          cmd_o.emit_last = 1'b1;
          state_d         = StIdle;
        end else if (sts_i.in_match) begin
          cmd_o.adv_in = 1'b1;
          state_d      = StCheck;
        end else if (sts_i.full) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_src  = SrcInput;
          cmd_o.emit_ovf  = 1'b1;
          cmd_o.emit_last = 1'b1;
          state_d         = StIdle;
        end else begin
          cmd_o.calc_lt = 1'b1;
          state_d       = StInsert;
        end
      end
      StInsert: begin
        cmd_o.insert = 1'b1;
        state_d      = StIdle;
      end
      StCheck: begin
        // the pending packet goes out; the head follows if it now matches
        cmd_o.emit      = 1'b1;
        cmd_o.emit_src  = SrcPending;
        cmd_o.emit_last = !sts_i.head_match;
        if (sts_i.head_match) begin
          cmd_o.adv_head = 1'b1;
          cmd_o.pop      = 1'b1;
        end else begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

/* rtl/srb_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_dp
// Datapath: expected key, sorted store of cells, pending and result registers.
// ----------------------------------------------------------------------------
module srb_dp import srb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     two_level_i,
  input  logic     unordered_i,
  input  srb_in_t  item_i,
  input  srb_cmd_t cmd_i,
  output srb_sts_t sts_o,
  output srb_out_t result_o,
  output logic     result_valid_o
);

  srb_in_t                 in_q;
  srb_in_t                 pend_q, pend_d;
  srb_in_t                 cell_q [StoreDepth];
  logic [StoreDepth-1:0]   lt_q;
  logic [StoreDepth-1:0]   ahead;
  logic [CntW-1:0]         count_q, count_d;
  logic [31:0]             exp_major_q, exp_major_d;
  logic [30:0]             exp_minor_q, exp_minor_d;
  srb_out_t                out_q;
  logic                    out_valid_q;
  srb_in_t                 adv_src;
  srb_in_t                 emit_item;

  assign sts_o.unordered  = unordered_i;
  assign sts_o.in_match   = key_match(in_q, exp_major_q, exp_minor_q, two_level_i);
  assign sts_o.full       = (count_q == CntW'(StoreDepth));
  assign sts_o.head_match = (count_q != '0) &&
                            key_match(cell_q[0], exp_major_q, exp_minor_q, two_level_i);

  // key advance, from the input packet or from the store head
  always_comb begin
    adv_src     = cmd_i.adv_head ? cell_q[0] : in_q;
    exp_major_d = exp_major_q;
    exp_minor_d = exp_minor_q;
    if (cmd_i.adv_in || cmd_i.adv_head) begin
      if (two_level_i) begin
        if (adv_src.end_of_chunk) begin
          exp_major_d = exp_major_q + 32'd1;
          exp_minor_d = '0;
        end else begin
          exp_minor_d = exp_minor_q + 31'd1;
        end
      end else begin
        exp_major_d = exp_major_q + {25'd0, adv_src.slot_count};
      end
    end
  end

  always_comb begin
    pend_d = pend_q;
    if (cmd_i.adv_in) begin
      pend_d = in_q;
    end else if (cmd_i.adv_head) begin
      pend_d = cell_q[0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.insert) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_major_q <= '0;
      exp_minor_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      exp_major_q <= exp_major_d;
      exp_minor_q <= exp_minor_d;
      count_q     <= count_d;
      out_valid_q <= cmd_i.emit;
    end
  end

  assign emit_item = (cmd_i.emit_src == SrcPending) ? pend_q : in_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= item_i;
    end
    pend_q <= pend_d;
    if (cmd_i.emit) begin
      out_q.out_chunk_id     <= emit_item.chunk_id;
      out_q.out_batch_id     <= emit_item.batch_id;
      out_q.out_end_of_chunk <= emit_item.end_of_chunk;
      out_q.out_offset       <= emit_item.data_offset;
      out_q.out_length       <= emit_item.data_length;
      out_q.overflow         <= cmd_i.emit_ovf;
      out_q.run_last         <= cmd_i.emit_last;
    end
  end

  // each cell compares its own entry with the new key
  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_lt) begin
      for (int i = 0; i < StoreDepth; i++) begin
        lt_q[i] <= (CntW'(i) < count_q) && key_lt(cell_q[i], in_q, two_level_i);
      end
    end
  end

  // only the leading run of smaller entries stays in place, the first other
  // entry marks the insert point even when a mode change left the store unsorted
  always_comb begin
    ahead[0] = lt_q[0];
    for (int i = 1; i < StoreDepth; i++) begin
      ahead[i] = ahead[i-1] & lt_q[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < StoreDepth; i++) begin
      if (cmd_i.insert) begin
        if (i == 0) begin
          if (!ahead[0]) begin
            cell_q[0] <= in_q;
          end
        end else if (!ahead[i-1]) begin
          cell_q[i] <= cell_q[i-1];
        end else if (!ahead[i]) begin
          cell_q[i] <= in_q;
        end
      end else if (cmd_i.pop && (i < StoreDepth - 1)) begin
        cell_q[i] <= cell_q[i+1];
      end
    end
  end

  assign result_o       = out_q;
  assign result_valid_o = out_valid_q;

endmodule

/* rtl/sequence_reorder_buffer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit
// Resequencer for completion packets with a sorted store of early packets.
// ----------------------------------------------------------------------------
// A packet is taken when start is high and busy is low. Results leave one per
// cycle on result_o, marked by result_valid_o, in the cycle after the decision
// that releases them; the receiver must take every result, and run_last marks
// the final result of each packet. A packet released at once or flagged as
// overflow keeps busy only through the decide state; a stored packet, through
// decide and insert (parallel key compare in every store cell, then the
// shift-insert). A matching packet holds busy through decide, then a check
// state for it and each packet drained behind it, one per cycle from the head.
module sequence_reorder_buffer_unit import srb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  srb_in_t     item_i,
  output srb_out_t    result_o,
  output logic        result_valid_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     two_level_q;
  logic     unordered_q;
  srb_cmd_t cmd;
  srb_sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_level_q <= 1'b1;
      unordered_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        AddrTwoLevel:  two_level_q <= pwdata[0];
        AddrUnordered: unordered_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      AddrTwoLevel:  prdata = {31'd0, two_level_q};
      AddrUnordered: prdata = {31'd0, unordered_q};
      default:       prdata = '0;
    endcase
  end

  srb_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  srb_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .two_level_i    (two_level_q),
    .unordered_i    (unordered_q),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

endmodule

/* rtl/srb_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_checker
// Port-level checks on transfer and result sequencing.
// ----------------------------------------------------------------------------
module srb_checker import srb_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input srb_out_t result_o,
  input logic     result_valid_o,
  input logic     pready
);

  // a taken transfer always raises busy in the cycle after it is taken
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("busy not raised after transfer");

  // a drain run is gapless until its last result
  a_run_gapless: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.run_last |=> result_valid_o)
    else $error("gap inside a result run");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.run_last |-> busy)
    else $error("idle while a result run is open");

  a_ovf_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.overflow |-> result_o.run_last)
    else $error("overflow result not alone");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind sequence_reorder_buffer_unit srb_checker u_srb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_o       (result_o),
  .result_valid_o (result_valid_o),
  .pready         (pready)
);

/* tb/sv/sequence_reorder_buffer_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_unit_test
// Self-checking bench for the resequencer: packets go in through the start /
// busy handshake, every released packet is compared with a software copy of
// the ordering rules (expected key, sorted store, drain, overflow, unordered
// bypass) under both key modes and several register settings.
// ----------------------------------------------------------------------------
class resequence_tracker;
  bit                   two_level = 1'b1;
  bit                   unordered = 1'b0;
  logic [31:0]          next_major = '0;
  logic [30:0]          next_minor = '0;
  srb_pkg::srb_in_t     held[$];
  srb_pkg::srb_out_t    pending_releases[$];
  int                   errors;
  int                   released;
  int                   overflows;
  int                   drained;

  function bit key_hits(srb_pkg::srb_in_t p);
    if (two_level) begin
      return p.chunk_id == next_major && p.batch_id == next_minor;
    end
    return p.chunk_id == next_major;
  endfunction

  function logic [62:0] order_key(srb_pkg::srb_in_t p);
    if (two_level) begin
      return {p.chunk_id, p.batch_id};
    end
    return {31'd0, p.chunk_id};
  endfunction

  function void step_key(srb_pkg::srb_in_t p);
    if (two_level) begin
      next_minor = next_minor + 31'd1;
      if (p.end_of_chunk) begin
        next_major = next_major + 32'd1;
        next_minor = '0;
      end
    end else begin
      next_major = next_major + {25'd0, p.slot_count};
    end
  endfunction

  function void queue_release(srb_pkg::srb_in_t p, bit ovf);
    srb_pkg::srb_out_t r;
    r.out_chunk_id     = p.chunk_id;
    r.out_batch_id     = p.batch_id;
    r.out_end_of_chunk = p.end_of_chunk;
    r.out_offset       = p.data_offset;
    r.out_length       = p.data_length;
    r.overflow         = ovf;
    r.run_last         = 1'b0;
    pending_releases.push_back(r);
  endfunction

  function void note_input(srb_pkg::srb_in_t p);
    int n;
    int pos;
    n = pending_releases.size();
    if (unordered || key_hits(p)) begin
      queue_release(p, 1'b0);
      if (!unordered) begin
        step_key(p);
        while (held.size() > 0 && key_hits(held[0])) begin
          queue_release(held[0], 1'b0);
          step_key(held[0]);
          void'(held.pop_front());
          drained++;
        end
      end
    end else if (held.size() >= srb_pkg::StoreDepth) begin
      queue_release(p, 1'b1);
      overflows++;
    end else begin
      pos = 0;
      while (pos < held.size() && order_key(held[pos]) < order_key(p)) pos++;
      held.insert(pos, p);
    end
    if (pending_releases.size() > n) begin
      pending_releases[pending_releases.size() - 1].run_last = 1'b1;
    end
  endfunction

  function void check_result(srb_pkg::srb_out_t got);
    srb_pkg::srb_out_t want;
    if (pending_releases.size() == 0) begin
      $display("%0t: unexpected transfer, expected none, got %h", $time, got);
      errors++;
      return;
    end
    want = pending_releases.pop_front();
    released++;
    if (got.out_chunk_id !== want.out_chunk_id)
      $display("%0t: chunk_id expected %h got %h", $time, want.out_chunk_id, got.out_chunk_id);
    if (got.out_batch_id !== want.out_batch_id)
      $display("%0t: batch_id expected %h got %h", $time, want.out_batch_id, got.out_batch_id);
    if (got.out_end_of_chunk !== want.out_end_of_chunk)
      $display("%0t: end_of_chunk expected %b got %b", $time, want.out_end_of_chunk,
               got.out_end_of_chunk);
    if (got.out_offset !== want.out_offset)
      $display("%0t: offset expected %h got %h", $time, want.out_offset, got.out_offset);
    if (got.out_length !== want.out_length)
      $display("%0t: length expected %h got %h", $time, want.out_length, got.out_length);
    if (got.overflow !== want.overflow)
      $display("%0t: overflow expected %b got %b", $time, want.overflow, got.overflow);
    if (got.run_last !== want.run_last)
      $display("%0t: run_last expected %b got %b", $time, want.run_last, got.run_last);
    if (got !== want) errors++;
  endfunction
endclass

module sequence_reorder_buffer_unit_test;
  import srb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  srb_in_t     item = '0;
  srb_out_t    result_o;
  logic        result_valid_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  resequence_tracker tracker = new();
  int idle_pct;
  int stall_cycles;
  int items_sent;

  sequence_reorder_buffer_unit uut (
    .clk_i, .rst_ni, .start, .busy, .item_i(item), .result_o, .result_valid_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) tracker.check_result(result_o);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= 3000) begin
      $display("FAIL sequence_reorder_buffer_unit");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_packet(input srb_in_t p);
    @(negedge clk_i);
    start = 1'b1;
    item  = p;
    do @(posedge clk_i); while (busy);
    tracker.note_input(p);
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
  endtask

  // let the block settle so register writes never overlap work
  task automatic wait_quiet();
    @(negedge clk_i);
    start = 1'b0;
    while (tracker.pending_releases.size() != 0 || busy) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] addr, input bit val);
    wait_quiet();
    psel = 1'b1; pwrite = 1'b1; paddr = addr; pwdata = {31'd0, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == AddrTwoLevel) tracker.two_level = val;
    else tracker.unordered = val;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  function automatic srb_in_t noise_packet();
    srb_in_t p;
    p.chunk_id     = $urandom;
    p.batch_id     = 31'($urandom);
    p.end_of_chunk = 1'($urandom);
    p.slot_count   = 7'($urandom);
    p.data_offset  = 48'({$urandom, $urandom});
    p.data_length  = 48'({$urandom, $urandom});
    return p;
  endfunction

  // a run of consecutive keys from the current expected key, sent shuffled
  task automatic send_run(input int n);
    srb_in_t     run[$];
    srb_in_t     p;
    logic [31:0] maj;
    logic [30:0] mnr;
    maj = tracker.next_major;
    mnr = tracker.next_minor;
    for (int k = 0; k < n; k++) begin
      p = noise_packet();
      p.chunk_id = maj;
      p.batch_id = mnr;
      p.end_of_chunk = ($urandom_range(3) == 0);
      p.slot_count = ($urandom_range(9) == 0) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(1, 64));
      run.push_back(p);
      if (tracker.two_level) begin
        mnr = mnr + 31'd1;
        if (p.end_of_chunk) begin
          maj = maj + 32'd1;
          mnr = '0;
        end
      end else begin
        maj = maj + {25'd0, p.slot_count};
      end
    end
    run.shuffle();
    foreach (run[k]) send_packet(run[k]);
  endtask

  task automatic random_phase(input int count);
    while (count > 0) begin
      if ($urandom_range(9) == 0) begin
        send_packet(noise_packet());
        count--;
      end else begin
        int n;
        n = $urandom_range(1, 6);
        send_run(n);
        count -= n;
      end
    end
  endtask

  initial begin
    srb_in_t p;
    stall_cycles = 0;
    items_sent   = 0;
    idle_pct     = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: early packets, drain with chunk end, extreme field values
    p = '0; p.slot_count = 7'd1;
    p.batch_id = 31'd2; p.end_of_chunk = 1'b1;
    p.data_offset = '1; p.data_length = '1;
    send_packet(p);
    p = '0; p.batch_id = 31'd1; p.data_offset = 48'h1; send_packet(p);
    p = '0; p.chunk_id = 32'd1; p.batch_id = 31'd0; send_packet(p);
    p = '0; p.chunk_id = 32'hFFFF_FFFF; p.batch_id = '1; p.end_of_chunk = 1'b1;
    p.slot_count = '1; send_packet(p);
    p = '0; send_packet(p);
    // equal key twice in store, newer one lands ahead
    p = '0; p.chunk_id = 32'd1; p.batch_id = 31'd2; p.data_length = 48'd7; send_packet(p);
    p.data_length = 48'd8; send_packet(p);
    p = '0; p.chunk_id = 32'd1; p.batch_id = 31'd1; send_packet(p);
    // flat mode with held entries from two-level, zero slot count
    reg_write(AddrTwoLevel, 1'b0);
    p = '0; p.chunk_id = tracker.next_major; p.slot_count = 7'd0; send_packet(p);
    p.slot_count = 7'd64; send_packet(p);
    p = '0; p.chunk_id = tracker.next_major + 32'd3; p.slot_count = 7'd1; send_packet(p);
    p = '0; p.chunk_id = tracker.next_major; p.slot_count = 7'd3; send_packet(p);
    reg_write(AddrUnordered, 1'b1);
    send_packet(noise_packet());
    p = '0; p.chunk_id = tracker.next_major; send_packet(p);
    reg_write(AddrTwoLevel, 1'b1);
    send_packet(noise_packet());
    reg_write(AddrUnordered, 1'b0);

    idle_pct = 19;
    random_phase(20);
    reg_write(AddrTwoLevel, 1'b0);
    idle_pct = 83;
    random_phase(20);
    reg_write(AddrTwoLevel, 1'b1);
    idle_pct = 0;
    random_phase(15);

    // fill the store with early packets until overflow, then bypass it
    while (tracker.held.size() < StoreDepth) begin
      p = noise_packet();
      p.chunk_id = tracker.next_major + 32'd1 + 32'($urandom_range(0, 3));
      send_packet(p);
    end
    repeat (3) begin
      p = noise_packet();
      p.chunk_id = tracker.next_major + 32'd2;
      send_packet(p);
    end
    reg_write(AddrUnordered, 1'b1);
    random_phase(4);
    reg_write(AddrUnordered, 1'b0);

    wait_quiet();
    repeat (20) @(negedge clk_i);
    if (tracker.pending_releases.size() != 0) begin
      $display("%0t: %0d releases never arrived", $time, tracker.pending_releases.size());
      tracker.errors++;
    end
    $display("covered %0d packets, %0d releases checked, %0d drained from store, %0d overflow",
             items_sent, tracker.released, tracker.drained, tracker.overflows);
    if (tracker.errors == 0) begin
      $display("PASS sequence_reorder_buffer_unit");
    end else begin
      $display("FAIL sequence_reorder_buffer_unit");
    end
    $finish;
  end
endmodule
